FILE: sv/ook_remote_frame_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// OOK remote frame encoder: assertion macros
// Shared property shapes for the checker of the frame encoder.
// ----------------------------------------------------------------------------
`ifndef OOK_REMOTE_FRAME_ENCODER_TOP_DEFINES_SVH
`define OOK_REMOTE_FRAME_ENCODER_TOP_DEFINES_SVH

// Checks that cons holds in the same cycle as ante. The rst_n argument is
// active low; the check is off while it is low.
`define OOKE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante.
`define OOKE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ooke_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OOK remote frame encoder package
// Sizes, codes, reset values and the types shared between the modules.
// ----------------------------------------------------------------------------
package ooke_pkg;

    // Frame geometry.
    localparam int MODE0_SYMBOLS = 12;
    localparam int MODE1_BITS    = 16;

    localparam int CODE_W = 24;
    localparam int PINS_W = 8;
    localparam int DUR_W  = 16;

    localparam int M0_DATA_SEGS = 4 * MODE0_SYMBOLS;
    localparam int M1_DATA_SEGS = 2 * MODE1_BITS;
    localparam int M0_SEGS      = M0_DATA_SEGS + 2;
    localparam int M1_SEGS      = M1_DATA_SEGS + 1;

    localparam int FLAG_W     = (M0_DATA_SEGS > M1_DATA_SEGS) ? M0_DATA_SEGS : M1_DATA_SEGS;
    localparam int MAX_SEGS   = (M0_SEGS > M1_SEGS) ? M0_SEGS : M1_SEGS;
    localparam int SEG_W      = $clog2(MAX_SEGS);
    localparam int FLAG_IDX_W = $clog2(FLAG_W);

    // Frame modes.
    localparam logic MODE_TRISTATE = 1'b0;
    localparam logic MODE_BINARY   = 1'b1;

    // Tristate symbol codes; the two remaining codes both mean float.
    localparam logic [1:0] SYM_ZERO = 2'd0;
    localparam logic [1:0] SYM_ONE  = 2'd1;

    // Long-pulse flags per segment, segment 0 in bit 0.
    localparam logic [3:0] PAT0_ZERO  = 4'b1010;
    localparam logic [3:0] PAT0_ONE   = 4'b0101;
    localparam logic [3:0] PAT0_FLOAT = 4'b0110;
    localparam logic [1:0] PAT1_ZERO  = 2'b10;
    localparam logic [1:0] PAT1_ONE   = 2'b01;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_M0_SHORT     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_M0_LONG      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_M0_SYNC_HIGH = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_M0_SYNC_LOW  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_M1_SHORT     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_M1_LONG      = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_M1_SYNC_LOW  = CFG_IDX_W'(6);

    // Register reset values in microseconds.
    localparam logic [DUR_W-1:0] RST_M0_SHORT     = DUR_W'(350);
    localparam logic [DUR_W-1:0] RST_M0_LONG      = DUR_W'(1050);
    localparam logic [DUR_W-1:0] RST_M0_SYNC_HIGH = DUR_W'(350);
    localparam logic [DUR_W-1:0] RST_M0_SYNC_LOW  = DUR_W'(10850);
    localparam logic [DUR_W-1:0] RST_M1_SHORT     = DUR_W'(350);
    localparam logic [DUR_W-1:0] RST_M1_LONG      = DUR_W'(1050);
    localparam logic [DUR_W-1:0] RST_M1_SYNC_LOW  = DUR_W'(10850);

    // Queue depths.
    localparam int DESC_DEPTH = 2;
    localparam int DESC_PTR_W = $clog2(DESC_DEPTH);
    localparam int DESC_CNT_W = $clog2(DESC_DEPTH + 1);
    localparam int SEGQ_DEPTH = 2;
    localparam int SEGQ_PTR_W = $clog2(SEGQ_DEPTH);
    localparam int SEGQ_CNT_W = $clog2(SEGQ_DEPTH + 1);

    // A classified frame waiting for the sequencer.
    typedef struct packed {
        logic              mode;
        logic [PINS_W-1:0] pins;
        logic [FLAG_W-1:0] long_flags;
    } t_desc;

    // One output segment.
    typedef struct packed {
        logic [PINS_W-1:0] drive_pins;
        logic              level;
        logic [DUR_W-1:0]  duration_us;
        logic              last;
    } t_seg;

    // A configuration register write.
    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] index;
        logic [DUR_W-1:0]     data;
    } t_cfg_wr;

endpackage

FILE: sv/ooke_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OOK frame encoder front end
// Accepts code words, turns them into per-segment long/short flags and holds
// them in a small descriptor queue for the sequencer.
// ----------------------------------------------------------------------------
module ooke_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic                       i_action,
    input  logic [ooke_pkg::CODE_W-1:0] i_code_word,
    input  logic [ooke_pkg::PINS_W-1:0] i_pin_mask,
    output logic                       o_desc_valid,
    output ooke_pkg::t_desc            o_desc,
    input  logic                       i_desc_take
);

    ooke_pkg::t_desc                     n_desc;
    ooke_pkg::t_desc                     r_q [ooke_pkg::DESC_DEPTH];
    logic [ooke_pkg::DESC_PTR_W-1:0]     r_wr;
    logic [ooke_pkg::DESC_PTR_W-1:0]     r_rd;
    logic [ooke_pkg::DESC_CNT_W-1:0]     r_cnt;
    logic                                push_ok;

    // Classify every symbol or bit in parallel into its flag pattern.
    always_comb begin
        n_desc            = '0;
        n_desc.mode       = i_action;
        n_desc.pins       = i_pin_mask;
        if (i_action == ooke_pkg::MODE_TRISTATE) begin
            for (int s = 0; s < ooke_pkg::MODE0_SYMBOLS; s++) begin
                case (i_code_word[2*s +: 2])
                    ooke_pkg::SYM_ZERO: n_desc.long_flags[4*s +: 4] = ooke_pkg::PAT0_ZERO;
                    ooke_pkg::SYM_ONE:  n_desc.long_flags[4*s +: 4] = ooke_pkg::PAT0_ONE;
                    default:            n_desc.long_flags[4*s +: 4] = ooke_pkg::PAT0_FLOAT;
                endcase
            end
        end else begin
            for (int b = 0; b < ooke_pkg::MODE1_BITS; b++) begin
                n_desc.long_flags[2*b +: 2] = i_code_word[b] ? ooke_pkg::PAT1_ONE
                                                             : ooke_pkg::PAT1_ZERO;
            end
        end
    end

    assign o_full       = (r_cnt == ooke_pkg::DESC_CNT_W'(ooke_pkg::DESC_DEPTH));
    assign push_ok      = i_push && !o_full;
    assign o_desc_valid = (r_cnt != '0);
    assign o_desc       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr] <= n_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == ooke_pkg::DESC_PTR_W'(ooke_pkg::DESC_DEPTH - 1))
                        ? '0 : r_wr + 1'b1;
            end
            if (i_desc_take) begin
                r_rd <= (r_rd == ooke_pkg::DESC_PTR_W'(ooke_pkg::DESC_DEPTH - 1))
                        ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !i_desc_take) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push_ok && i_desc_take) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/ooke_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OOK frame encoder sequencer
// Holds the timing registers and walks one frame descriptor, producing one
// segment per cycle whenever the result queue has room.
// ----------------------------------------------------------------------------
module ooke_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ooke_pkg::t_cfg_wr   i_cfg,
    input  logic                i_desc_valid,
    input  ooke_pkg::t_desc     i_desc,
    output logic                o_desc_take,
    input  logic                i_seg_full,
    output logic                o_seg_valid,
    output ooke_pkg::t_seg      o_seg
);

    logic [ooke_pkg::DUR_W-1:0] r_m0_short;
    logic [ooke_pkg::DUR_W-1:0] r_m0_long;
    logic [ooke_pkg::DUR_W-1:0] r_m0_sync_high;
    logic [ooke_pkg::DUR_W-1:0] r_m0_sync_low;
    logic [ooke_pkg::DUR_W-1:0] r_m1_short;
    logic [ooke_pkg::DUR_W-1:0] r_m1_long;
    logic [ooke_pkg::DUR_W-1:0] r_m1_sync_low;

    logic                       r_busy;
    logic [ooke_pkg::SEG_W-1:0] r_seg;
    ooke_pkg::t_desc            r_desc;

    logic [ooke_pkg::SEG_W-1:0] data_segs;
    logic [ooke_pkg::DUR_W-1:0] short_d;
    logic [ooke_pkg::DUR_W-1:0] long_d;
    logic                       emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m0_short     <= ooke_pkg::RST_M0_SHORT;
            r_m0_long      <= ooke_pkg::RST_M0_LONG;
            r_m0_sync_high <= ooke_pkg::RST_M0_SYNC_HIGH;
            r_m0_sync_low  <= ooke_pkg::RST_M0_SYNC_LOW;
            r_m1_short     <= ooke_pkg::RST_M1_SHORT;
            r_m1_long      <= ooke_pkg::RST_M1_LONG;
            r_m1_sync_low  <= ooke_pkg::RST_M1_SYNC_LOW;
        end else if (i_cfg.en) begin
            unique case (i_cfg.index)
                ooke_pkg::CFG_M0_SHORT:     r_m0_short     <= i_cfg.data;
                ooke_pkg::CFG_M0_LONG:      r_m0_long      <= i_cfg.data;
                ooke_pkg::CFG_M0_SYNC_HIGH: r_m0_sync_high <= i_cfg.data;
                ooke_pkg::CFG_M0_SYNC_LOW:  r_m0_sync_low  <= i_cfg.data;
                ooke_pkg::CFG_M1_SHORT:     r_m1_short     <= i_cfg.data;
                ooke_pkg::CFG_M1_LONG:      r_m1_long      <= i_cfg.data;
                ooke_pkg::CFG_M1_SYNC_LOW:  r_m1_sync_low  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Data segments alternate high and low starting high; the sync tail follows.
    always_comb begin
        if (r_desc.mode == ooke_pkg::MODE_BINARY) begin
            data_segs = ooke_pkg::SEG_W'(ooke_pkg::M1_DATA_SEGS);
            short_d   = r_m1_short;
            long_d    = r_m1_long;
        end else begin
            data_segs = ooke_pkg::SEG_W'(ooke_pkg::M0_DATA_SEGS);
            short_d   = r_m0_short;
            long_d    = r_m0_long;
        end

        o_seg.drive_pins  = r_desc.pins;
        o_seg.level       = ~r_seg[0];
        o_seg.duration_us = r_desc.long_flags[r_seg[ooke_pkg::FLAG_IDX_W-1:0]] ? long_d
                                                                             : short_d;
        o_seg.last        = 1'b0;

        if (r_seg >= data_segs) begin
            if (r_desc.mode == ooke_pkg::MODE_BINARY) begin
                o_seg.level       = 1'b0;
                o_seg.duration_us = r_m1_sync_low;
                o_seg.last        = 1'b1;
            end else if (r_seg == data_segs) begin
                o_seg.level       = 1'b1;
                o_seg.duration_us = r_m0_sync_high;
            end else begin
                o_seg.level       = 1'b0;
                o_seg.duration_us = r_m0_sync_low;
                o_seg.last        = 1'b1;
            end
        end
    end

    assign emit        = r_busy && !i_seg_full;
    assign o_seg_valid = emit;
    // The next frame loads in the same cycle the current one sends its last segment.
    assign o_desc_take = i_desc_valid && (!r_busy || (emit && o_seg.last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_seg  <= '0;
        end else begin
            if (o_desc_take) begin
                r_busy <= 1'b1;
                r_seg  <= '0;
                r_desc <= i_desc;
            end else if (emit && o_seg.last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_seg <= r_seg + 1'b1;
            end
        end
    end

endmodule

FILE: sv/ooke_seg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OOK frame encoder result queue
// Two-entry queue that decouples the sequencer from the result consumer.
// ----------------------------------------------------------------------------
module ooke_seg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  ooke_pkg::t_seg  i_seg,
    output logic            o_full,
    output logic            o_empty,
    input  logic            i_pop,
    output ooke_pkg::t_seg  o_seg
);

    ooke_pkg::t_seg                  r_q [ooke_pkg::SEGQ_DEPTH];
    logic [ooke_pkg::SEGQ_PTR_W-1:0] r_wr;
    logic [ooke_pkg::SEGQ_PTR_W-1:0] r_rd;
    logic [ooke_pkg::SEGQ_CNT_W-1:0] r_cnt;
    logic                            pop_ok;

    assign o_full  = (r_cnt == ooke_pkg::SEGQ_CNT_W'(ooke_pkg::SEGQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign pop_ok  = i_pop && !o_empty;
    assign o_seg   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wr] <= i_seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wr <= (r_wr == ooke_pkg::SEGQ_PTR_W'(ooke_pkg::SEGQ_DEPTH - 1))
                        ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == ooke_pkg::SEGQ_PTR_W'(ooke_pkg::SEGQ_DEPTH - 1))
                        ? '0 : r_rd + 1'b1;
            end
            if (i_wr && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && pop_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/ook_remote_frame_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OOK remote frame encoder
// Expands one remote-control code word into the on-off-keyed pin segments.
// ----------------------------------------------------------------------------
// Usage. Code words enter through a queue-style port: a beat is taken at a
// clock edge where i_push is high and o_full is low. Each beat yields a frame
// of segments (level, duration in microseconds, pin mask, last flag): 50
// segments for a tristate frame and 33 for a binary frame. Segments leave
// through a queue-style port: while o_empty is low the oldest segment is on
// the result ports and it is taken at an edge where i_pop is high.
// The first segment of a frame shows once its beat has passed the descriptor
// queue, the sequencer registers and the result queue. Throughput: one
// segment per cycle while the result queue has room; a segment counter walks
// each frame; frames follow each other with no gap. A two-entry descriptor
// queue lets new beats be taken while a frame is still being sent.
// Timing registers are written through the cfg port (always ready) and must
// change only while the block is idle. Reset is synchronous, active low: it
// empties both queues, stops the sequencer and restores the default timings.
// When the receiver stalls, the result queue fills, the sequencer holds its
// place, and o_full rises once the descriptor queue is full too.
// ----------------------------------------------------------------------------
module ook_remote_frame_encoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Code word input.
    input  logic                            i_push,
    output logic                            o_full,
    input  logic                            i_action,
    input  logic [ooke_pkg::CODE_W-1:0]     i_code_word,
    input  logic [ooke_pkg::PINS_W-1:0]     i_pin_mask,
    // Segment output.
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic [ooke_pkg::PINS_W-1:0]     o_drive_pins,
    output logic                            o_level,
    output logic [ooke_pkg::DUR_W-1:0]      o_duration_us,
    output logic                            o_last,
    // Timing register writes.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ooke_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ooke_pkg::DUR_W-1:0]      i_cfg_data
);

    ooke_pkg::t_desc   desc;
    logic              desc_valid;
    logic              desc_take;
    ooke_pkg::t_seg    seg_in;
    ooke_pkg::t_seg    seg_out;
    logic              seg_valid;
    logic              seg_full;
    ooke_pkg::t_cfg_wr cfg_wr;

    // The register file takes a write every cycle.
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.en    = i_cfg_valid && o_cfg_ready;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    ooke_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_action     (i_action),
        .i_code_word  (i_code_word),
        .i_pin_mask   (i_pin_mask),
        .o_desc_valid (desc_valid),
        .o_desc       (desc),
        .i_desc_take  (desc_take)
    );

    ooke_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_wr),
        .i_desc_valid (desc_valid),
        .i_desc       (desc),
        .o_desc_take  (desc_take),
        .i_seg_full   (seg_full),
        .o_seg_valid  (seg_valid),
        .o_seg        (seg_in)
    );

    ooke_seg_queue u_seg_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (seg_valid),
        .i_seg   (seg_in),
        .o_full  (seg_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_seg   (seg_out)
    );

    assign o_drive_pins  = seg_out.drive_pins;
    assign o_level       = seg_out.level;
    assign o_duration_us = seg_out.duration_us;
    assign o_last        = seg_out.last;

endmodule

FILE: sv/ooke_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OOK remote frame encoder checker
// Port-level properties of the frame encoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "ook_remote_frame_encoder_top_defines.svh"

module ooke_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_full,
    input logic                            o_empty,
    input logic                            i_pop,
    input logic [ooke_pkg::PINS_W-1:0]     o_drive_pins,
    input logic                            o_level,
    input logic [ooke_pkg::DUR_W-1:0]      o_duration_us,
    input logic                            o_last
);

    // Reset leaves both queues empty.
    `OOKE_ASSERT_NEXT(a_reset_clears, i_clk, 1'b1, !i_rst_n, o_empty && !o_full, "queues not empty after reset")

    // A waiting segment stays put until it is taken.
    `OOKE_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !o_empty && !i_pop, !o_empty && $stable(o_duration_us) && $stable(o_level) && $stable(o_last) && $stable(o_drive_pins), "waiting segment changed")

    // Every frame ends on a low gap.
    `OOKE_ASSERT_SAME(a_last_is_low, i_clk, i_rst_n, !o_empty && o_last, !o_level, "final segment is not low")

    // All segments of one frame drive the same pins.
    `OOKE_ASSERT_NEXT(a_pins_in_frame, i_clk, i_rst_n, !o_empty && i_pop && !o_last, o_empty || (o_drive_pins == $past(o_drive_pins)), "pin mask changed inside a frame")

endmodule

bind ook_remote_frame_encoder_top ooke_checker u_ooke_checker (.*);

FILE: bench/ook_remote_frame_encoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OOK remote frame encoder testbench
// Drives code words into the frame encoder under changing timing registers and
// checks every emitted pin segment against a frame predictor kept in a small
// scoreboard. Both queue ports idle and stall at random, the receiver holds
// off long enough to fill the block, and the sender waits for it to drain between phases.
// ----------------------------------------------------------------------------
module ook_remote_frame_encoder_top_tb;

    import ooke_pkg::*;

    // Clock period halves in ns.
    localparam int HALF_PERIOD   = 10;
    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT   = 4000;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES   = 600;
    // Cycles allowed for the pipeline to settle once nothing is expected.
    localparam int SETTLE_CYCLES = 8;
    // Number of mapped timing registers.
    localparam int NUM_TIMING    = int'(CFG_M1_SYNC_LOW) + 1;
    // An index past the last timing register; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = '1;

    localparam logic LVL_HIGH = 1'b1;
    localparam logic LVL_LOW  = 1'b0;

    // Receiver stall patterns, picked at random by the receiver.
    typedef enum int {
        POP_ALWAYS,
        POP_COIN,
        POP_SPARSE,
        POP_BURSTY
    } t_pop_style;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the segments of each accepted code word from its
    // own copy of the timing registers and checks the segments that leave
    // the block in order.
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [DUR_W-1:0] timing [NUM_TIMING];
        t_seg             segs_due [$];
        int               errors;
        int               segs_checked;
        int               frames_seen [2];

        function new();
            errors = 0;
            segs_checked = 0;
            frames_seen[0] = 0;
            frames_seen[1] = 0;
            timing[CFG_M0_SHORT]     = RST_M0_SHORT;
            timing[CFG_M0_LONG]      = RST_M0_LONG;
            timing[CFG_M0_SYNC_HIGH] = RST_M0_SYNC_HIGH;
            timing[CFG_M0_SYNC_LOW]  = RST_M0_SYNC_LOW;
            timing[CFG_M1_SHORT]     = RST_M1_SHORT;
            timing[CFG_M1_LONG]      = RST_M1_LONG;
            timing[CFG_M1_SYNC_LOW]  = RST_M1_SYNC_LOW;
        endfunction

        function void set_timing(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] val);
            if (idx <= CFG_M1_SYNC_LOW) begin
                timing[idx] = val;
            end
        endfunction

        function void add_seg(logic [PINS_W-1:0] pins, logic lvl,
                              logic [DUR_W-1:0] dur, logic fin);
            t_seg seg;
            seg.drive_pins  = pins;
            seg.level       = lvl;
            seg.duration_us = dur;
            seg.last        = fin;
            segs_due.push_back(seg);
        endfunction

        function void note_code_word(logic action, logic [CODE_W-1:0] code,
                                     logic [PINS_W-1:0] pins);
            logic [DUR_W-1:0] s;
            logic [DUR_W-1:0] l;
            logic [DUR_W-1:0] d0;
            logic [DUR_W-1:0] d1;
            logic [DUR_W-1:0] d2;
            logic [DUR_W-1:0] d3;
            logic [1:0]       sym;
            frames_seen[action]++;
            if (action == MODE_TRISTATE) begin
                s = timing[CFG_M0_SHORT];
                l = timing[CFG_M0_LONG];
                for (int k = 0; k < MODE0_SYMBOLS; k++) begin
                    sym = code[2*k +: 2];
                    case (sym)
                        SYM_ZERO: begin
                            d0 = s; d1 = l; d2 = s; d3 = l;
                        end
                        SYM_ONE: begin
                            d0 = l; d1 = s; d2 = l; d3 = s;
                        end
                        default: begin
                            d0 = s; d1 = l; d2 = l; d3 = s;
                        end
                    endcase
                    add_seg(pins, LVL_HIGH, d0, 1'b0);
                    add_seg(pins, LVL_LOW,  d1, 1'b0);
                    add_seg(pins, LVL_HIGH, d2, 1'b0);
                    add_seg(pins, LVL_LOW,  d3, 1'b0);
                end
                add_seg(pins, LVL_HIGH, timing[CFG_M0_SYNC_HIGH], 1'b0);
                add_seg(pins, LVL_LOW,  timing[CFG_M0_SYNC_LOW],  1'b1);
            end else begin
                s = timing[CFG_M1_SHORT];
                l = timing[CFG_M1_LONG];
                for (int k = 0; k < MODE1_BITS; k++) begin
                    if (code[k]) begin
                        add_seg(pins, LVL_HIGH, l, 1'b0);
                        add_seg(pins, LVL_LOW,  s, 1'b0);
                    end else begin
                        add_seg(pins, LVL_HIGH, s, 1'b0);
                        add_seg(pins, LVL_LOW,  l, 1'b0);
                    end
                end
                add_seg(pins, LVL_LOW, timing[CFG_M1_SYNC_LOW], 1'b1);
            end
        endfunction

        function void check_segment(t_seg got);
            t_seg want;
            if (segs_due.size() == 0) begin
                $error("segment with nothing expected: pins %0h level %0d dur %0d last %0d",
                       got.drive_pins, got.level, got.duration_us, got.last);
                errors++;
                return;
            end
            want = segs_due.pop_front();
            segs_checked++;
            if (got.drive_pins !== want.drive_pins) begin
                $error("drive_pins: expected %0h, got %0h", want.drive_pins, got.drive_pins);
                errors++;
            end
            if (got.level !== want.level) begin
                $error("level: expected %0d, got %0d", want.level, got.level);
                errors++;
            end
            if (got.duration_us !== want.duration_us) begin
                $error("duration_us: expected %0d, got %0d", want.duration_us, got.duration_us);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test.
    // ------------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_push;
    logic                 o_full;
    logic                 i_action;
    logic [CODE_W-1:0]    i_code_word;
    logic [PINS_W-1:0]    i_pin_mask;
    logic                 o_empty;
    logic                 i_pop;
    logic [PINS_W-1:0]    o_drive_pins;
    logic                 o_level;
    logic [DUR_W-1:0]     o_duration_us;
    logic                 o_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DUR_W-1:0]     i_cfg_data;

    ook_remote_frame_encoder_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_action      (i_action),
        .i_code_word   (i_code_word),
        .i_pin_mask    (i_pin_mask),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_drive_pins  (o_drive_pins),
        .o_level       (o_level),
        .o_duration_us (o_duration_us),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    frame_scoreboard sb;

    // Set by the stimulus to ask the receiver for one long hold-off; the
    // receiver counts the hold itself and clears the flag when done.
    bit hold_req = 1'b0;

    int full_stall_cycles = 0;
    int cfg_writes        = 0;
    int idle_cycles       = 0;

    // Free-running clock, low for the first half period.
    initial i_clk = 1'b0;
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, where the block's
    // registers still hold their pre-edge values. Input beats are noted before
    // output beats are checked so the order within the edge is fixed.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_seg got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_timing(i_cfg_index, i_cfg_data);
                cfg_writes++;
            end
            if (i_push && o_full) begin
                full_stall_cycles++;
            end
            if (i_push && !o_full) begin
                sb.note_code_word(i_action, i_code_word, i_pin_mask);
            end
            if (i_pop && !o_empty) begin
                got.drive_pins  = o_drive_pins;
                got.level       = o_level;
                got.duration_us = o_duration_us;
                got.last        = o_last;
                sb.check_segment(got);
            end
        end
    end

    // Watchdog: any beat on any port counts as progress. The longest correct
    // quiet stretch is the receiver hold-off, well under the limit.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty) || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat for %0d cycles, %0d segments still expected.",
                         idle_cycles, sb.segs_due.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Pops on a pattern redrawn at random as the run goes on: always
    // ready, coin toss, rarely ready, or in bursts. On request it holds off
    // for HOLD_CYCLES so the segment and descriptor queues fill and o_full
    // rises while the sender keeps pushing.
    // ------------------------------------------------------------------------
    initial begin : receiver
        t_pop_style style;
        int         tick;
        i_pop = 1'b0;
        style = POP_ALWAYS;
        tick  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (tick % 48 == 0) begin
                    style = t_pop_style'($urandom_range(0, 3));
                end
                tick++;
                case (style)
                    POP_ALWAYS: i_pop <= 1'b1;
                    POP_COIN:   i_pop <= 1'($urandom_range(0, 1));
                    POP_SPARSE: i_pop <= ($urandom_range(0, 3) == 0);
                    default:    i_pop <= ((tick / 8) % 2 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Inputs change only at the falling edge; a beat is done at
    // the first rising edge where o_full is low.
    // ------------------------------------------------------------------------
    task automatic push_code_word(logic action, logic [CODE_W-1:0] code,
                                  logic [PINS_W-1:0] pins);
        @(negedge i_clk);
        i_push      <= 1'b1;
        i_action    <= action;
        i_code_word <= code;
        i_pin_mask  <= pins;
        do begin
            @(posedge i_clk);
        end while (o_full);
    endtask

    // Drops push and idles the input; n, at least one, sets the length of the gap.
    task automatic idle_input(int n);
        @(negedge i_clk);
        i_push <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Sends random code words in bursts of one to eight, with random gaps
    // between bursts; about a quarter of the bursts follow with no gap.
    task automatic run_random_frames(int count);
        int burst;
        int gap;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst && sent < count; b++) begin
                push_code_word(1'($urandom_range(0, 1)), CODE_W'($urandom),
                               PINS_W'($urandom));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                idle_input(gap);
            end
        end
        idle_input(1);
    endtask

    // Holds the sender until every predicted segment has left the block, then
    // waits out SETTLE_CYCLES so the pipeline can go quiet.
    task automatic wait_for_drain();
        while (sb.segs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_timing(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all_timing(logic [DUR_W-1:0] m0_short, logic [DUR_W-1:0] m0_long,
                                    logic [DUR_W-1:0] m0_sync_high,
                                    logic [DUR_W-1:0] m0_sync_low,
                                    logic [DUR_W-1:0] m1_short, logic [DUR_W-1:0] m1_long,
                                    logic [DUR_W-1:0] m1_sync_low);
        write_timing(CFG_M0_SHORT,     m0_short);
        write_timing(CFG_M0_LONG,      m0_long);
        write_timing(CFG_M0_SYNC_HIGH, m0_sync_high);
        write_timing(CFG_M0_SYNC_LOW,  m0_sync_low);
        write_timing(CFG_M1_SHORT,     m1_short);
        write_timing(CFG_M1_LONG,      m1_long);
        write_timing(CFG_M1_SYNC_LOW,  m1_sync_low);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence. Each phase sets the timing registers while the block is
    // idle, then streams code words. The first phase runs on reset timings.
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        i_rst_n     = 1'b0;
        i_push      = 1'b0;
        i_action    = MODE_TRISTATE;
        i_code_word = '0;
        i_pin_mask  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_M0_SHORT;
        i_cfg_data  = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames on reset timings. Tristate words cover all-zero,
        // all-one and all-float symbols (both float codes) and a mix of every
        // symbol code; binary words cover all-zero, all-one, alternating bits,
        // a lone first or last bit, and set bits above the sixteen that are
        // sent, which must be ignored. Pin masks reach both extremes.
        push_code_word(MODE_TRISTATE, 24'h000000, 8'h00);
        push_code_word(MODE_TRISTATE, 24'h555555, 8'hFF);
        push_code_word(MODE_TRISTATE, 24'hAAAAAA, 8'h5A);
        push_code_word(MODE_TRISTATE, 24'hFFFFFF, 8'hA5);
        push_code_word(MODE_TRISTATE, 24'hE4E4E4, 8'h01);
        push_code_word(MODE_TRISTATE, 24'h1B1B1B, 8'h80);
        push_code_word(MODE_BINARY,   24'h000000, 8'hFF);
        push_code_word(MODE_BINARY,   24'h00FFFF, 8'h00);
        push_code_word(MODE_BINARY,   24'hFF0000, 8'h3C);
        push_code_word(MODE_BINARY,   24'hFFFFFF, 8'hC3);
        push_code_word(MODE_BINARY,   24'h005555, 8'h0F);
        push_code_word(MODE_BINARY,   24'h7EAAAA, 8'hF0);
        push_code_word(MODE_BINARY,   24'hAB0001, 8'h42);
        push_code_word(MODE_BINARY,   24'h008000, 8'h24);
        idle_input(1);
        run_random_frames(60);
        wait_for_drain();

        // Zero durations: every segment comes out with length zero.
        write_all_timing('0, '0, '0, '0, '0, '0, '0);
        push_code_word(MODE_TRISTATE, 24'hE4E4E4, 8'h99);
        push_code_word(MODE_BINARY,   24'h00A5A5, 8'h66);
        idle_input(1);
        run_random_frames(58);
        wait_for_drain();

        // Largest durations, then a write to an unmapped index that must
        // leave every register alone.
        write_all_timing('1, '1, '1, '1, '1, '1, '1);
        write_timing(CFG_UNMAPPED, DUR_W'($urandom));
        push_code_word(MODE_TRISTATE, 24'h3C3C3C, 8'hE7);
        push_code_word(MODE_BINARY,   24'h00C33C, 8'h18);
        idle_input(1);
        run_random_frames(68);
        wait_for_drain();

        // Random durations. Partway through, the receiver holds off for a
        // long stretch while the sender keeps offering words, so the block
        // fills and pushes back.
        write_all_timing(DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom),
                         DUR_W'($urandom), DUR_W'($urandom), DUR_W'($urandom),
                         DUR_W'($urandom));
        run_random_frames(25);
        hold_req = 1'b1;
        run_random_frames(45);
        wait_for_drain();

        // Mixed extremes: short and long swapped in size between the modes.
        // The sender also stops midway until the block is empty.
        write_all_timing(DUR_W'(1), '1, '0, '1, '1, '0, DUR_W'(1));
        write_timing(CFG_UNMAPPED, '0);
        run_random_frames(35);
        wait_for_drain();
        run_random_frames(35);
        wait_for_drain();

        // Back to the power-on timings, written explicitly this time.
        write_all_timing(RST_M0_SHORT, RST_M0_LONG, RST_M0_SYNC_HIGH, RST_M0_SYNC_LOW,
                         RST_M1_SHORT, RST_M1_LONG, RST_M1_SYNC_LOW);
        run_random_frames(70);
        wait_for_drain();

        $display("Run covered %0d tristate and %0d binary frames, %0d segments, %0d register writes.",
                 sb.frames_seen[MODE_TRISTATE], sb.frames_seen[MODE_BINARY], sb.segs_checked,
                 cfg_writes);
        $display("Input was held back by a full block for %0d cycles; %0d mismatches found.",
                 full_stall_cycles, sb.errors);
        if (sb.errors == 0 && sb.segs_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
